// ===== src/mctw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctw_pkg: shared types and codes for the multi-channel task watchdog
// Entry layout, command/status/event codes and controller states.
// ----------------------------------------------------------------------------
package mctw_pkg;

    localparam int ENTRIES = 16;
    localparam int K_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_PET  = 3'd1;
    localparam logic [2:0] FN_REM  = 3'd2;
    localparam logic [2:0] FN_ENA  = 3'd3;
    localparam logic [2:0] FN_SCAN = 3'd4;
    localparam logic [2:0] FN_TICK = 3'd5;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INVALID  = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_PRESENT  = 3'd3;
    localparam logic [2:0] STS_NOTFOUND = 3'd4;

    localparam logic [2:0] EV_DONE     = 3'd0;
    localparam logic [2:0] EV_APPROACH = 3'd1;
    localparam logic [2:0] EV_LOGGED   = 3'd2;
    localparam logic [2:0] EV_KILL     = 3'd3;
    localparam logic [2:0] EV_RESET    = 3'd4;
    localparam logic [2:0] EV_SCANDONE = 3'd5;

    localparam logic [1:0] SEV_KILL  = 2'd1;
    localparam logic [1:0] SEV_RESET = 2'd2;

    localparam logic       CFG_TICK     = 1'b0;
    localparam logic       CFG_INTERVAL = 1'b1;

    localparam logic [15:0] KC_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] timeout;
        logic [31:0] last_pet;
        logic [1:0]  sev;
        logic [15:0] kc;
        logic        en;
        logic        killed;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_SHIFT,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== src/mctw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctw_cell: one table slot of the watchdog ring
// Holds one client entry and takes its neighbor's entry when advanced.
// ----------------------------------------------------------------------------
module mctw_cell (
    input  wire              i_clk,
    input  wire              i_adv,
    input  wire mctw_pkg::t_entry i_nbr,
    output mctw_pkg::t_entry o_ent
);

    mctw_pkg::t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ent <= i_nbr;
        end
    end

    assign o_ent = r_ent;

endmodule
`default_nettype wire

// ===== src/multi_channel_task_watchdog.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: an item runs through PASS over every entry, then SHIFT (only for a remove
//   that hits), then FIN; output stalls hold it. One item is worked at a time.
// Throughput: set by the ring of entry cells, which rotates once per cycle while the
//   output is not stalled, so every entry passes the head once per item.
// Reset: synchronous active low; clears count, clock, interval counter and the
//   config registers (tick 1 ms, interval 1000 ms). Table cells are not cleared.
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog: top level
// Rotating ring of client cells with a controller that runs commands and scans.
// ----------------------------------------------------------------------------
module multi_channel_task_watchdog (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_func,
    input  wire  [31:0] i_client_id,
    input  wire  [31:0] i_timeout_limit_ms,
    input  wire  [1:0]  i_severity_level,
    input  wire         i_enable_flag,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_event_client,
    output logic [31:0] o_elapsed_ms,
    output logic [15:0] o_kill_count,
    output logic        o_last_result,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int N = mctw_pkg::ENTRIES;

    mctw_pkg::t_state r_state, n_state;
    mctw_pkg::t_entry w_cell [N];
    mctw_pkg::t_entry w_nbr  [N];
    mctw_pkg::t_entry w_head, w_tail;
    logic [N-1:0]     w_adv;

    logic [mctw_pkg::K_W-1:0]   r_k, r_pos;
    logic [mctw_pkg::CNT_W-1:0] r_count;
    logic [31:0] r_now;
    logic [15:0] r_since, r_intv;
    logic [9:0]  r_tick;
    logic [2:0]  r_func;
    logic [31:0] r_id, r_to;
    logic [1:0]  r_sev;
    logic        r_en, r_scan, r_found, r_quiet, r_inval, r_full;

    logic        r_out_valid, r_last;
    logic [2:0]  r_status, r_ev;
    logic [31:0] r_cl, r_el;
    logic [15:0] r_kc;

    logic        w_accept, w_ofree, w_step, w_vk, w_match, w_found_set, w_pos_set;
    logic        w_emit, w_e_last, w_quiet_set, w_shift, w_cnt_inc;
    logic [2:0]  w_e_st, w_e_ev;
    logic [31:0] w_e_cl, w_e_el, w_el;
    logic [15:0] w_e_kc;
    logic [16:0] w_since_sum;

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_ring
            if (j < N - 1) begin : g_mid
                assign w_nbr[j] = w_cell[j+1];
            end else begin : g_end
                assign w_nbr[j] = w_step ? w_tail : w_cell[j];
            end
            assign w_adv[j] = w_step ||
                (w_shift && (mctw_pkg::CNT_W'(j) >= mctw_pkg::CNT_W'(r_pos)));
            mctw_cell u_cell (
                .i_clk (i_clk),
                .i_adv (w_adv[j]),
                .i_nbr (w_nbr[j]),
                .o_ent (w_cell[j])
            );
        end
    endgenerate

    assign w_head      = w_cell[0];
    assign w_accept    = i_in_valid && (r_state == mctw_pkg::S_IDLE);
    assign w_ofree     = !r_out_valid || !i_out_stall;
    assign w_step      = (r_state == mctw_pkg::S_PASS) && w_ofree;
    assign w_shift     = (r_state == mctw_pkg::S_SHIFT);
    assign w_since_sum = {1'b0, r_since} + {7'b0, r_tick};
    assign w_vk        = mctw_pkg::CNT_W'(r_k) < r_count;
    assign w_match     = w_vk && !r_inval && (w_head.id == r_id);
    assign w_el        = r_now - w_head.last_pet;

    always_comb begin
        n_state     = r_state;
        w_tail      = w_head;
        w_found_set = 1'b0;
        w_pos_set   = 1'b0;
        w_quiet_set = 1'b0;
        w_cnt_inc   = 1'b0;
        w_emit      = 1'b0;
        w_e_last    = 1'b0;
        w_e_st      = mctw_pkg::STS_OK;
        w_e_ev      = mctw_pkg::EV_DONE;
        w_e_cl      = '0;
        w_e_el      = '0;
        w_e_kc      = '0;
        unique case (r_state)
            mctw_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = mctw_pkg::S_PASS;
                end
            end
            mctw_pkg::S_PASS: begin
                if (w_step) begin
                    if (r_scan) begin
                        if (w_vk && w_head.en && !r_quiet) begin
                            w_e_cl = w_head.id;
                            w_e_el = w_el;
                            w_e_kc = w_head.kc;
                            if (w_el > w_head.timeout) begin
                                w_emit = 1'b1;
                                w_e_ev = mctw_pkg::EV_LOGGED;
                                if (w_head.sev == mctw_pkg::SEV_KILL) begin
                                    if (!w_head.killed) begin
                                        w_tail.killed = 1'b1;
                                        if (w_head.kc != mctw_pkg::KC_MAX) begin
                                            w_tail.kc = w_head.kc + 16'd1;
                                        end
                                        w_e_kc = w_tail.kc;
                                        w_e_ev = mctw_pkg::EV_KILL;
                                    end
                                end else if (w_head.sev == mctw_pkg::SEV_RESET) begin
                                    w_e_ev      = mctw_pkg::EV_RESET;
                                    w_e_last    = 1'b1;
                                    w_quiet_set = 1'b1;
                                end
                            end else if (w_el > {1'b0, w_head.timeout[31:1]}) begin
                                w_emit = 1'b1;
                                w_e_ev = mctw_pkg::EV_APPROACH;
                            end
                        end
                    end else begin
                        case (r_func)
                            mctw_pkg::FN_ADD: begin
                                if (w_match) begin
                                    w_found_set = 1'b1;
                                end
                                if ((mctw_pkg::CNT_W'(r_k) == r_count) && !r_inval &&
                                    !r_full && !r_found) begin
                                    w_tail.id       = r_id;
                                    w_tail.timeout  = r_to;
                                    w_tail.last_pet = r_now;
                                    w_tail.sev      = r_sev;
                                    w_tail.kc       = '0;
                                    w_tail.en       = 1'b1;
                                    w_tail.killed   = 1'b0;
                                end
                            end
                            mctw_pkg::FN_PET: begin
                                if (w_match && w_head.en) begin
                                    w_found_set     = 1'b1;
                                    w_tail.last_pet = r_now;
                                end
                            end
                            mctw_pkg::FN_ENA: begin
                                if (w_match) begin
                                    w_found_set = 1'b1;
                                    w_tail.en   = r_en;
                                    if (r_en) begin
                                        w_tail.last_pet = r_now;
                                    end
                                end
                            end
                            mctw_pkg::FN_REM: begin
                                if (w_match) begin
                                    w_found_set = 1'b1;
                                    w_pos_set   = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_k == mctw_pkg::K_W'(N - 1)) begin
                        if (!r_scan && (r_func == mctw_pkg::FN_REM) &&
                            (r_found || w_found_set)) begin
                            n_state = mctw_pkg::S_SHIFT;
                        end else begin
                            n_state = mctw_pkg::S_FIN;
                        end
                    end
                end
            end
            mctw_pkg::S_SHIFT: begin
                n_state = mctw_pkg::S_FIN;
            end
            mctw_pkg::S_FIN: begin
                if (r_scan && r_quiet) begin
                    n_state = mctw_pkg::S_IDLE;
                end else if (w_ofree) begin
                    n_state  = mctw_pkg::S_IDLE;
                    w_emit   = 1'b1;
                    w_e_last = 1'b1;
                    if (r_scan) begin
                        w_e_ev = mctw_pkg::EV_SCANDONE;
                    end else if (r_inval) begin
                        w_e_st = mctw_pkg::STS_INVALID;
                    end else begin
                        case (r_func)
                            mctw_pkg::FN_ADD: begin
                                if (r_full) begin
                                    w_e_st = mctw_pkg::STS_FULL;
                                end else if (r_found) begin
                                    w_e_st = mctw_pkg::STS_PRESENT;
                                end else begin
                                    w_cnt_inc = 1'b1;
                                end
                            end
                            mctw_pkg::FN_PET, mctw_pkg::FN_ENA, mctw_pkg::FN_REM: begin
                                if (!r_found) begin
                                    w_e_st = mctw_pkg::STS_NOTFOUND;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = mctw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mctw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_now       <= '0;
            r_since     <= '0;
            r_tick      <= 10'd1;
            r_intv      <= 16'd1000;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_quiet     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mctw_pkg::CFG_TICK) begin
                    r_tick <= i_cfg_data[9:0];
                end else begin
                    r_intv <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_k     <= '0;
                r_found <= 1'b0;
                r_quiet <= 1'b0;
                if (i_func == mctw_pkg::FN_TICK) begin
                    r_now <= r_now + {22'b0, r_tick};
                    if (w_since_sum >= {1'b0, r_intv}) begin
                        r_since <= '0;
                    end else begin
                        r_since <= w_since_sum[15:0];
                    end
                end
            end
            if (w_step) begin
                r_k <= r_k + mctw_pkg::K_W'(1);
                if (w_found_set) begin
                    r_found <= 1'b1;
                end
                if (w_quiet_set) begin
                    r_quiet <= 1'b1;
                end
            end
            if (w_shift) begin
                r_count <= r_count - mctw_pkg::CNT_W'(1);
            end else if (w_cnt_inc) begin
                r_count <= r_count + mctw_pkg::CNT_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item fields and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_id    <= i_client_id;
            r_to    <= i_timeout_limit_ms;
            r_sev   <= i_severity_level;
            r_en    <= i_enable_flag;
            r_inval <= (i_func <= mctw_pkg::FN_ENA) && (i_client_id == 32'd0);
            r_full  <= (r_count == mctw_pkg::CNT_W'(N));
            r_scan  <= (i_func == mctw_pkg::FN_SCAN) ||
                       ((i_func == mctw_pkg::FN_TICK) && (w_since_sum >= {1'b0, r_intv}));
        end
        if (w_pos_set) begin
            r_pos <= r_k;
        end
        if (w_emit) begin
            r_status <= w_e_st;
            r_ev     <= w_e_ev;
            r_cl     <= w_e_cl;
            r_el     <= w_e_el;
            r_kc     <= w_e_kc;
            r_last   <= w_e_last;
        end
    end

    assign o_in_stall     = (r_state != mctw_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_event_res    = r_ev;
    assign o_event_client = r_cl;
    assign o_elapsed_ms   = r_el;
    assign o_kill_count   = r_kc;
    assign o_last_result  = r_last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mctw_pkg::CNT_W'(N))
        else $error("entry count above table size");

    a_ring_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctw_pkg::S_PASS) && !w_ofree |=> $stable(r_k))
        else $error("ring advanced while output blocked");

    a_shift_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctw_pkg::S_SHIFT) |-> (r_found && (r_func == mctw_pkg::FN_REM)))
        else $error("compaction without a matched remove");

    // a system reset event ends the results early but the ring still finishes its turn
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctw_pkg::S_FIN) && w_emit && w_e_last |=>
        (r_state == mctw_pkg::S_IDLE))
        else $error("final result issued but controller still busy");
`endif

endmodule
`default_nettype wire

// ===== verif/mctw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctw_checker: result predictor and scoreboard for the task watchdog
// Watches both item channels and the config port, keeps a private copy of the
// client table, and compares each result item with the oldest expected one.
// ----------------------------------------------------------------------------
module mctw_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [2:0]  i_func,
    input  wire  [31:0] i_client_id,
    input  wire  [31:0] i_timeout_limit_ms,
    input  wire  [1:0]  i_severity_level,
    input  wire         i_enable_flag,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [2:0]  i_status,
    input  wire  [2:0]  i_event_res,
    input  wire  [31:0] i_event_client,
    input  wire  [31:0] i_elapsed_ms,
    input  wire  [15:0] i_kill_count,
    input  wire         i_last_result,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results_seen,
    output int          o_scan_events
);

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  ev;
        logic [31:0] client;
        logic [31:0] elapsed;
        logic [15:0] kc;
        logic        last;
    } t_result;

    mctw_pkg::t_entry clients[mctw_pkg::ENTRIES];
    int          n_clients;
    logic [31:0] clock_ms;
    logic [15:0] since_scan;
    logic [9:0]  tick_step;
    logic [15:0] interval;
    t_result     expected_q[$];

    function automatic int lookup(logic [31:0] id);
        for (int i = 0; i < n_clients; i++)
            if (clients[i].id == id) return i;
        return -1;
    endfunction

    task automatic push(logic [2:0] st, logic [2:0] ev, logic [31:0] cl,
                        logic [31:0] el, logic [15:0] kc);
        t_result r;
        r = '{st, ev, cl, el, kc, 1'b0};
        expected_q.push_back(r);
    endtask

    task automatic predict_scan();
        logic [31:0] el;
        for (int i = 0; i < n_clients; i++) begin
            if (!clients[i].en) continue;
            el = clock_ms - clients[i].last_pet;
            if (el > clients[i].timeout) begin
                if (clients[i].sev == mctw_pkg::SEV_KILL) begin
                    if (!clients[i].killed) begin
                        clients[i].killed = 1'b1;
                        if (clients[i].kc != mctw_pkg::KC_MAX) clients[i].kc++;
                        push(mctw_pkg::STS_OK, mctw_pkg::EV_KILL, clients[i].id, el,
                             clients[i].kc);
                    end else begin
                        push(mctw_pkg::STS_OK, mctw_pkg::EV_LOGGED, clients[i].id, el,
                             clients[i].kc);
                    end
                end else if (clients[i].sev == mctw_pkg::SEV_RESET) begin
                    push(mctw_pkg::STS_OK, mctw_pkg::EV_RESET, clients[i].id, el,
                         clients[i].kc);
                    return;
                end else begin
                    push(mctw_pkg::STS_OK, mctw_pkg::EV_LOGGED, clients[i].id, el,
                         clients[i].kc);
                end
            end else if (el > (clients[i].timeout >> 1)) begin
                push(mctw_pkg::STS_OK, mctw_pkg::EV_APPROACH, clients[i].id, el,
                     clients[i].kc);
            end
        end
        push(mctw_pkg::STS_OK, mctw_pkg::EV_SCANDONE, '0, '0, '0);
    endtask

    task automatic predict_item();
        logic [2:0] st;
        logic [16:0] sum;
        int p;
        st = mctw_pkg::STS_OK;
        if (i_func == mctw_pkg::FN_SCAN) begin
            predict_scan();
        end else if (i_func == mctw_pkg::FN_TICK) begin
            sum = since_scan + tick_step;
            clock_ms += tick_step;
            if (sum >= interval) begin
                since_scan = '0;
                predict_scan();
            end else begin
                since_scan = sum[15:0];
                push(mctw_pkg::STS_OK, mctw_pkg::EV_DONE, '0, '0, '0);
            end
        end else begin
            p = lookup(i_client_id);
            if (i_func <= mctw_pkg::FN_ENA && i_client_id == '0) begin
                st = mctw_pkg::STS_INVALID;
            end else if (i_func == mctw_pkg::FN_ADD) begin
                if (n_clients >= mctw_pkg::ENTRIES) st = mctw_pkg::STS_FULL;
                else if (p >= 0) st = mctw_pkg::STS_PRESENT;
                else begin
                    clients[n_clients] = '{i_client_id, i_timeout_limit_ms, clock_ms,
                                           i_severity_level, 16'd0, 1'b1, 1'b0};
                    n_clients++;
                end
            end else if (i_func == mctw_pkg::FN_PET) begin
                if (p >= 0 && clients[p].en) clients[p].last_pet = clock_ms;
                else st = mctw_pkg::STS_NOTFOUND;
            end else if (i_func == mctw_pkg::FN_REM) begin
                if (p < 0) st = mctw_pkg::STS_NOTFOUND;
                else begin
                    for (int j = p; j + 1 < n_clients; j++) clients[j] = clients[j + 1];
                    n_clients--;
                end
            end else if (i_func == mctw_pkg::FN_ENA) begin
                if (p < 0) st = mctw_pkg::STS_NOTFOUND;
                else begin
                    clients[p].en = i_enable_flag;
                    if (i_enable_flag) clients[p].last_pet = clock_ms;
                end
            end
            push(st, mctw_pkg::EV_DONE, '0, '0, '0);
        end
        expected_q[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            n_clients      <= 0;
            clock_ms       <= '0;
            since_scan     <= '0;
            tick_step      <= 10'd1;
            interval       <= 16'd1000;
            o_errors       <= 0;
            o_results_seen <= 0;
            o_scan_events  <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mctw_pkg::CFG_TICK) tick_step = i_cfg_data[9:0];
                else interval = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_item();
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_event_res, i_event_client, i_elapsed_ms,
                        i_kill_count, i_last_result};
                o_results_seen <= o_results_seen + 1;
                if (i_event_res != mctw_pkg::EV_DONE && i_event_res != mctw_pkg::EV_SCANDONE)
                    o_scan_events <= o_scan_events + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected st=%0d ev=%0d cl=%h el=%h kc=%h last=%b",
                                 $time, want.status, want.ev, want.client, want.elapsed,
                                 want.kc, want.last);
                        $display("%0t:          actual   st=%0d ev=%0d cl=%h el=%h kc=%h last=%b",
                                 $time, got.status, got.ev, got.client, got.elapsed,
                                 got.kc, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_q.size();

endmodule

// ===== verif/tb_multi_channel_task_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_task_watchdog: stimulus and verdict for the task watchdog
// Directed corner cases, then random command/tick traffic under bursty
// sending and patterned output stalls across several timing settings.
// ----------------------------------------------------------------------------
module tb_multi_channel_task_watchdog;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [31:0] client_id = '0;
    logic [31:0] tmo_limit = '0;
    logic [1:0]  severity = '0;
    logic        enable = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [2:0]  event_res;
    logic [31:0] event_client;
    logic [31:0] elapsed_ms;
    logic [15:0] kill_count;
    logic        last_result;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    int          errors, pending, results_seen, scan_events;
    int          hold_off = 0;
    int          items_sent = 0;
    logic [31:0] known_ids[8];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_channel_task_watchdog dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_client_id(client_id), .i_timeout_limit_ms(tmo_limit),
        .i_severity_level(severity), .i_enable_flag(enable),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_event_res(event_res), .o_event_client(event_client),
        .o_elapsed_ms(elapsed_ms), .o_kill_count(kill_count),
        .o_last_result(last_result),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mctw_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_client_id(client_id), .i_timeout_limit_ms(tmo_limit),
        .i_severity_level(severity), .i_enable_flag(enable),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_event_res(event_res), .i_event_client(event_client),
        .i_elapsed_ms(elapsed_ms), .i_kill_count(kill_count),
        .i_last_result(last_result),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_results_seen(results_seen), .o_scan_events(scan_events)
    );

    // output stall pattern; a long hold-off overrides it
    always @(posedge clk) begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off  <= hold_off - 1;
        end else begin
            case ((items_sent / 40) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send(logic [2:0] f, logic [31:0] id, logic [31:0] to,
                        logic [1:0] sev, logic en);
        func       <= f;
        client_id  <= id;
        tmo_limit  <= to;
        severity   <= sev;
        enable     <= en;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (mctw_pkg::ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item();
        logic [31:0] id;
        logic [31:0] to;
        logic [1:0]  sev;
        logic        en;
        int r;
        r   = $urandom_range(0, 99);
        id  = ($urandom_range(0, 9) == 0) ? $urandom : known_ids[$urandom_range(0, 7)];
        to  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
        sev = 2'($urandom_range(0, 3));
        en  = 1'($urandom);
        if (r < 25) send(mctw_pkg::FN_ADD, id, to, sev, en);
        else if (r < 45) send(mctw_pkg::FN_PET, id, $urandom, sev, en);
        else if (r < 52) send(mctw_pkg::FN_REM, id, $urandom, sev, en);
        else if (r < 60) send(mctw_pkg::FN_ENA, id, $urandom, sev, en);
        else if (r < 68) send(mctw_pkg::FN_SCAN, $urandom, $urandom, sev, en);
        else if (r < 97) send(mctw_pkg::FN_TICK, $urandom, $urandom, sev, en);
        else send(3'($urandom_range(6, 7)), $urandom, $urandom, sev, en);
    endtask

    initial begin
        known_ids[0] = 32'h0000_0000;
        known_ids[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) known_ids[i] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table fill, errors, each severity, all function codes
        write_cfg(mctw_pkg::CFG_TICK, 16'd1000);
        write_cfg(mctw_pkg::CFG_INTERVAL, 16'd65535);
        send(mctw_pkg::FN_ADD, 32'd0, 32'd5, 2'd0, 1'b0);
        send(mctw_pkg::FN_ADD, 32'hFFFF_FFFF, 32'd1500, 2'd1, 1'b1);
        send(mctw_pkg::FN_ADD, 32'hFFFF_FFFF, 32'd5, 2'd0, 1'b0);
        send(mctw_pkg::FN_ADD, 32'h1, 32'hFFFF_FFFF, 2'd0, 1'b0);
        send(mctw_pkg::FN_ADD, 32'h2, 32'd2500, 2'd3, 1'b0);
        send(mctw_pkg::FN_ADD, 32'h3, 32'd0, 2'd2, 1'b0);
        send(mctw_pkg::FN_PET, 32'h4, '0, '0, '0);
        send(mctw_pkg::FN_ENA, 32'h3, '0, '0, 1'b0);
        send(mctw_pkg::FN_PET, 32'h3, '0, '0, '0);
        send(mctw_pkg::FN_TICK, '0, '0, '0, '0);
        send(mctw_pkg::FN_TICK, '0, '0, '0, '0);
        send(mctw_pkg::FN_SCAN, '0, '0, '0, '0);
        send(mctw_pkg::FN_ENA, 32'h3, '0, '0, 1'b1);
        send(mctw_pkg::FN_TICK, '0, '0, '0, '0);
        send(mctw_pkg::FN_SCAN, '0, '0, '0, '0);
        send(mctw_pkg::FN_REM, 32'h1, '0, '0, '0);
        send(mctw_pkg::FN_REM, 32'h1, '0, '0, '0);
        send(3'd6, '0, '0, '0, '0);
        send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1);
        for (int i = 0; i < 15; i++)
            send(mctw_pkg::FN_ADD, 32'h100 + 32'(i), 32'd50, 2'd0, 1'b0);
        send(mctw_pkg::FN_ADD, 32'h200, 32'd50, 2'd0, 1'b0);
        drain();

        // random phases over tick and interval settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_cfg(mctw_pkg::CFG_TICK, 16'd1);
                    write_cfg(mctw_pkg::CFG_INTERVAL, 16'd1);
                end
                1: begin
                    write_cfg(mctw_pkg::CFG_TICK, 16'd7);
                    write_cfg(mctw_pkg::CFG_INTERVAL, 16'd30);
                end
                2: begin
                    write_cfg(mctw_pkg::CFG_TICK, 16'd1023);
                    write_cfg(mctw_pkg::CFG_INTERVAL, 16'd65535);
                end
                3: begin
                    write_cfg(mctw_pkg::CFG_TICK, 16'd20);
                    write_cfg(mctw_pkg::CFG_INTERVAL, 16'd100);
                end
                default: begin
                    write_cfg(mctw_pkg::CFG_TICK, 16'd512);
                    write_cfg(mctw_pkg::CFG_INTERVAL, 16'd1000);
                end
            endcase
            // remove every known id from the table between phases; entries with other ids stay
            for (int k = 0; k < 8; k++) send(mctw_pkg::FN_REM, known_ids[k], '0, '0, '0);
            for (int k = 0; k < 31; k++) begin
                if (ph == 2 && k == 10) hold_off <= 400;
                random_item();
                gap();
            end
            drain();
        end

        $display("covered %0d items, %0d results, %0d client events over 6 timing settings",
                 items_sent, results_seen, scan_events);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
